@@ src/tmtf_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the threshold move-to-front cache
// used by tmtf_cell and threshold_move_to_front_cache_core
package tmtf_pkg;

	localparam int CNT_W = 8;
	localparam int FIELD_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
	localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;
	localparam logic [CNT_W-1:0] THRESH_RESET = 8'd3;

	// lookup result rippling from the front cell toward the rear
	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] cnt;
	} chain_t;

	// step control broadcast to every cell
	typedef struct packed {
		logic             step;
		logic             miss;
		logic             promote;
		logic [CNT_W-1:0] cnt_new;
	} ctrl_t;

endpackage

@@ src/threshold_move_to_front_cache_core.sv @@
`timescale 1ns / 1ps
// results appear in an output register in the cycle after a word is accepted
// one word per cycle unless the output side stalls; set by the compare and shift along the cell row
// a new word is taken while a result waits unless the output side stalls
// reset: all slots invalid, occupancy zero, promote threshold 3; slot keys and counts unreset
// depends on tmtf_pkg and tmtf_cell
module threshold_move_to_front_cache_core #(
	parameter int DEPTH = 4,
	parameter int KEY_WIDTH = 32,
	localparam int OCC_W = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tmtf_pkg::FIELD_W-1:0]       key_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [tmtf_pkg::CNT_W-1:0]         count_after,
	output logic                               promoted,
	output logic                               evicted,
	output logic [tmtf_pkg::FIELD_W-1:0]       evicted_key,
	output logic [OCC_W-1:0]                   occupancy,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tmtf_pkg::CNT_W-1:0]         cfg_data
);

	// stored key width, at most the input field; evicted_key bits above it are always zero
	localparam int SKW = (KEY_WIDTH < tmtf_pkg::FIELD_W) ? KEY_WIDTH : tmtf_pkg::FIELD_W;

	logic [tmtf_pkg::CNT_W-1:0] thr_q;
	logic [OCC_W-1:0]           occ_q;
	logic                       out_valid_q;
	logic                       hit_q;
	logic [tmtf_pkg::CNT_W-1:0] count_q;
	logic                       promoted_q;
	logic                       evicted_q;
	logic [tmtf_pkg::FIELD_W-1:0] evicted_key_q;

	logic [SKW-1:0]             key_s;
	logic                       accept;
	logic                       found;
	logic [tmtf_pkg::CNT_W-1:0] cnt_inc;
	logic                       promote;
	tmtf_pkg::ctrl_t            ctrl;

	tmtf_pkg::chain_t           chain [DEPTH+1];
	logic [SKW-1:0]             cell_key [DEPTH];
	logic [tmtf_pkg::CNT_W-1:0] cell_cnt [DEPTH];
	logic [DEPTH-1:0]           cell_valid;

	assign key_s    = key_value[SKW-1:0];
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	assign chain[0] = '0;
	assign found    = chain[DEPTH].found;
	assign cnt_inc  = (chain[DEPTH].cnt == tmtf_pkg::CNT_MAX) ? tmtf_pkg::CNT_MAX
	                                                          : chain[DEPTH].cnt + 1'b1;
	// a hit on the front slot stays in place
	assign promote  = found && (cnt_inc > thr_q) && !chain[1].found;

	assign ctrl.step    = accept;
	assign ctrl.miss    = ~found;
	assign ctrl.promote = promote;
	assign ctrl.cnt_new = found ? cnt_inc : tmtf_pkg::CNT_ONE;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_front
			tmtf_cell #(.KW(SKW)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.key_in     (key_s),
				.prev_key   (key_s),
				.prev_cnt   (ctrl.cnt_new),
				.prev_valid (1'b1),
				.chain_in   (chain[i]),
				.chain_out  (chain[i+1]),
				.key_q      (cell_key[i]),
				.cnt_q      (cell_cnt[i]),
				.valid_q    (cell_valid[i])
			);
		end else begin : g_rest
			tmtf_cell #(.KW(SKW)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.key_in     (key_s),
				.prev_key   (cell_key[i-1]),
				.prev_cnt   (cell_cnt[i-1]),
				.prev_valid (cell_valid[i-1]),
				.chain_in   (chain[i]),
				.chain_out  (chain[i+1]),
				.key_q      (cell_key[i]),
				.cnt_q      (cell_cnt[i]),
				.valid_q    (cell_valid[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tmtf_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				if (!found && occ_q != OCC_W'(DEPTH)) begin
					occ_q <= occ_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q      <= found;
			count_q    <= ctrl.cnt_new;
			promoted_q <= promote;
			evicted_q  <= ~found & cell_valid[DEPTH-1];
			if (!found && cell_valid[DEPTH-1]) begin
				evicted_key_q <= tmtf_pkg::FIELD_W'(cell_key[DEPTH-1]);
			end else begin
				evicted_key_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign count_after = count_q;
	assign promoted    = promoted_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign occupancy   = occ_q;

`ifndef SYNTHESIS
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == occ_q)
		else $error("occupancy disagrees with valid slots");

	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + 1'b1)) == '0)
		else $error("valid slots do not form a run from the front");

	a_promote_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && promoted_q |-> hit_q && !evicted_q)
		else $error("promotion without a hit");

	a_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !found && cell_valid[DEPTH-1] |=> occ_q == OCC_W'(DEPTH) && evicted_q)
		else $error("eviction from a table that was not full");
`endif

endmodule

@@ src/tmtf_cell.sv @@
`timescale 1ns / 1ps
// one slot of the ordered table: key, hit count and valid bit
// depends on tmtf_pkg for chain_t and ctrl_t
module tmtf_cell #(
	parameter int KW = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tmtf_pkg::ctrl_t                ctrl,
	input  logic [KW-1:0]                  key_in,
	input  logic [KW-1:0]                  prev_key,
	input  logic [tmtf_pkg::CNT_W-1:0]     prev_cnt,
	input  logic                           prev_valid,
	input  tmtf_pkg::chain_t               chain_in,
	output tmtf_pkg::chain_t               chain_out,
	output logic [KW-1:0]                  key_q,
	output logic [tmtf_pkg::CNT_W-1:0]     cnt_q,
	output logic                           valid_q
);

	logic match;
	logic first;
	logic shift;

	assign match = valid_q && (key_q == key_in);
	assign first = match && !chain_in.found;

	assign chain_out.found = chain_in.found | match;
	assign chain_out.cnt   = first ? cnt_q : chain_in.cnt;

	// on a promotion every slot up to and including the hit one moves back
	assign shift = ctrl.miss | (ctrl.promote & !chain_in.found);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.step && shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (shift) begin
				key_q <= prev_key;
				cnt_q <= prev_cnt;
			end else if (first) begin
				cnt_q <= ctrl.cnt_new;
			end
		end
	end

endmodule
